@@ rtl/curupira2_block_encrypt_macros.svh @@
// Assertion macros shared by the block encryption pipeline.
`ifndef CURUPIRA2_BLOCK_ENCRYPT_MACROS_SVH
`define CURUPIRA2_BLOCK_ENCRYPT_MACROS_SVH

// Implication checked in the same cycle; the consequent may carry a fixed delay.
`define C2BE_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> cons) \
      else $error(msg);

// Implication checked in the cycle after the antecedent.
`define C2BE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/c2be_pkg.sv @@
// Types, constants and byte functions of the Curupira-2 encryption pipeline.
package c2be_pkg;

   localparam int HALF_BITS      = 48;
   localparam int BLOCK_BYTES    = 12;
   localparam int ROUND_COUNT_DEF = 10;

   localparam logic [7:0] XMUL_POLY = 8'h4D;
   localparam logic [3:0] NIB_HI    = 4'hC;
   localparam logic [3:0] NIB_LO    = 4'h3;

   // Configuration register indexes.
   localparam logic CSR_KEY_UPPER = 1'b0;
   localparam logic CSR_KEY_LOWER = 1'b1;

   // Byte 0 is the most significant byte of the packed vector.
   typedef logic [0:BLOCK_BYTES-1][7:0] c2be_bytes_type;

   typedef struct packed {
      c2be_bytes_type blk;
      c2be_bytes_type key;
   } c2be_state_type;

   typedef struct packed {
      logic           valid;
      c2be_state_type data;
   } c2be_stage_type;

   localparam logic [3:0] MINI_P [16] = '{
      4'h3, 4'hF, 4'hE, 4'h0, 4'h5, 4'h4, 4'hB, 4'hC,
      4'hD, 4'hA, 4'h9, 4'h6, 4'h7, 4'h8, 4'h2, 4'h1
   };
   localparam logic [3:0] MINI_Q [16] = '{
      4'h9, 4'hE, 4'h5, 4'h6, 4'hA, 4'h2, 4'h3, 4'hC,
      4'hF, 4'h0, 4'h4, 4'hD, 4'h7, 4'hB, 4'h1, 4'h8
   };

   // S-box built from three passes over the mini-boxes.
   function automatic logic [7:0] sbox(input logic [7:0] v);
      logic [3:0] hi;
      logic [3:0] lo;
      logic [3:0] mid;
      logic [3:0] lo2;
      logic [3:0] hi2;
      logic [3:0] lo3;
      hi  = MINI_P[v[7:4]];
      lo  = MINI_Q[v[3:0]];
      mid = MINI_Q[(hi & NIB_HI) ^ {2'b00, lo[3:2]}];
      lo2 = MINI_P[{hi[1:0], 2'b00} ^ (lo & NIB_LO)];
      hi2 = MINI_P[(mid & NIB_HI) ^ {2'b00, lo2[3:2]}];
      lo3 = MINI_Q[{mid[1:0], 2'b00} ^ (lo2 & NIB_LO)];
      return {hi2, lo3};
   endfunction

   function automatic logic [7:0] xmul(input logic [7:0] v);
      logic [7:0] s;
      s = {v[6:0], 1'b0};
      return v[7] ? (s ^ XMUL_POLY) : s;
   endfunction

   function automatic logic [7:0] tee0(input logic [7:0] v);
      return {v[2:0], 5'b00000} ^ {v[4:0], 3'b000};
   endfunction

   function automatic logic [7:0] tee1(input logic [7:0] v);
      return v ^ (v >> 3) ^ (v >> 5);
   endfunction

   // Key addition: the first byte of each triple of the key goes through the S-box.
   function automatic c2be_bytes_type add_key(input c2be_bytes_type b,
                                             input c2be_bytes_type k);
      c2be_bytes_type r;
      r = b;
      for (int i = 0; i < BLOCK_BYTES; i += 3) begin
         r[i]   = b[i]   ^ sbox(k[i]);
         r[i+1] = b[i+1] ^ k[i+1];
         r[i+2] = b[i+2] ^ k[i+2];
      end
      return r;
   endfunction

endpackage

@@ rtl/c2be_if.sv @@
// Request and response channel interfaces of the encryption pipeline.
interface c2be_req_if;
   import c2be_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [HALF_BITS-1:0] block_upper;
   logic [HALF_BITS-1:0] block_lower;

   modport source (output valid, output block_upper, output block_lower, input ready);
   modport sink   (input valid, input block_upper, input block_lower, output ready);
endinterface

interface c2be_rsp_if;
   import c2be_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [HALF_BITS-1:0] cipher_upper;
   logic [HALF_BITS-1:0] cipher_lower;

   modport source (output valid, output cipher_upper, output cipher_lower, input ready);
   modport sink   (input valid, input cipher_upper, input cipher_lower, output ready);
endinterface

@@ rtl/c2be_whiten_cell.sv @@
// Entry cell of the pipeline: registers the block after the whitening key addition.
module c2be_whiten_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  c2be_pkg::c2be_bytes_type in_blk,
   input  c2be_pkg::c2be_bytes_type in_key,
   output c2be_pkg::c2be_stage_type out_link,
   input  logic                    out_ready
);
   import c2be_pkg::*;

   logic           valid_ff;
   logic           valid_in;
   c2be_state_type data_ff;
   logic           load;

   assign in_ready = !valid_ff || out_ready;
   assign load     = in_valid && in_ready;
   assign valid_in = load || (valid_ff && !out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff.blk <= add_key(in_blk, in_key);
         data_ff.key <= in_key;
      end
   end

   assign out_link.valid = valid_ff;
   assign out_link.data  = data_ff;

endmodule

@@ rtl/c2be_round_cell.sv @@
// One round cell: byte swap, S-box layer, key evolution, optional mix and key addition.
module c2be_round_cell #(
   parameter int ROUND_IDX  = 0,
   parameter bit LAST_ROUND = 1'b0
) (
   input  logic                    clock,
   input  logic                    reset,
   input  c2be_pkg::c2be_stage_type in_link,
   output logic                    in_ready,
   output c2be_pkg::c2be_stage_type out_link,
   input  logic                    out_ready
);
   import c2be_pkg::*;

   localparam logic [7:0] ROUND_CONST = sbox(8'(ROUND_IDX));

   logic           valid_ff;
   logic           valid_in;
   c2be_state_type data_ff;
   c2be_state_type data_in;
   logic           load;

   c2be_bytes_type swapped;
   c2be_bytes_type subbed;
   c2be_bytes_type mixed;
   c2be_bytes_type key_next;
   logic [7:0]     fb;
   logic [7:0]     t;
   logic [7:0]     u;

   assign in_ready = !valid_ff || out_ready;
   assign load     = in_link.valid && in_ready;
   assign valid_in = load || (valid_ff && !out_ready);

   always_comb begin
      swapped     = in_link.data.blk;
      swapped[1]  = in_link.data.blk[4];
      swapped[4]  = in_link.data.blk[1];
      swapped[2]  = in_link.data.blk[8];
      swapped[8]  = in_link.data.blk[2];
      swapped[7]  = in_link.data.blk[10];
      swapped[10] = in_link.data.blk[7];
      swapped[5]  = in_link.data.blk[11];
      swapped[11] = in_link.data.blk[5];
      for (int i = 0; i < BLOCK_BYTES; i++) begin
         subbed[i] = sbox(swapped[i]);
      end

      fb = in_link.data.key[0] ^ ROUND_CONST;
      for (int i = 0; i < BLOCK_BYTES - 1; i++) begin
         key_next[i] = in_link.data.key[i+1];
      end
      key_next[BLOCK_BYTES-3] = in_link.data.key[BLOCK_BYTES-2] ^ tee1(fb);
      key_next[BLOCK_BYTES-2] = in_link.data.key[BLOCK_BYTES-1] ^ tee0(fb);
      key_next[BLOCK_BYTES-1] = fb;

      mixed = subbed;
      t     = '0;
      u     = '0;
      if (!LAST_ROUND) begin
         for (int i = 0; i < BLOCK_BYTES; i += 3) begin
            t          = xmul(subbed[i] ^ subbed[i+1] ^ subbed[i+2]);
            u          = xmul(t);
            mixed[i]   = subbed[i]   ^ t;
            mixed[i+1] = subbed[i+1] ^ u;
            mixed[i+2] = subbed[i+2] ^ t ^ u;
         end
      end

      data_in.blk = add_key(mixed, key_next);
      data_in.key = key_next;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data_in;
      end
   end

   assign out_link.valid = valid_ff;
   assign out_link.data  = data_ff;

endmodule

@@ rtl/curupira2_block_encrypt.sv @@
// Top level of the Curupira-2 block encryption pipeline with its key registers.
// Usage
//    The key is written through the csr_ port: index 0 loads key bytes 0 to 5, index 1
//    loads key bytes 6 to 11, byte 0 in the top bits. Both halves reset to zero, and the
//    key is only to be changed while no block is in flight.
//    Plaintext arrives as a beat on req_bus and the ciphertext leaves as a beat on
//    rsp_bus, both with a valid and ready handshake.
// Timing
//    The data path is a row of cells: one whitening cell followed by one cell per
//    round, each carrying a block together with its evolving round key. Every cell is a
//    register stage, so a block passes through the whitening cell and then each round
//    cell in turn before it leaves. One beat is taken every cycle while the receiver
//    keeps up, since each cell takes a new block while its own block moves on.
// Stalls and reset
//    Each cell holds its block while the cell after it is full and stalled, so when
//    rsp_bus.ready is low the row fills up from the output end and req_bus.ready drops
//    only once every cell holds a block. Empty cells keep accepting meanwhile.
//    Reset empties every cell and clears the key; under stalls no beat is lost or repeated.
module curupira2_block_encrypt #(
   parameter int ROUND_COUNT = c2be_pkg::ROUND_COUNT_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   c2be_req_if.sink                       req_bus,
   c2be_rsp_if.source                     rsp_bus,
   input  logic                           csr_wr_en,
   input  logic                           csr_index,
   input  logic [c2be_pkg::HALF_BITS-1:0] csr_wr_data
);
   import c2be_pkg::*;

   `include "curupira2_block_encrypt_macros.svh"

   // Key registers; loading them only while the pipeline is idle is left to the user.
   logic [HALF_BITS-1:0] key_upper_ff;
   logic [HALF_BITS-1:0] key_lower_ff;
   logic [HALF_BITS-1:0] key_upper_in;
   logic [HALF_BITS-1:0] key_lower_in;

   always_comb begin
      key_upper_in = key_upper_ff;
      key_lower_in = key_lower_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_KEY_UPPER: key_upper_in = csr_wr_data;
            CSR_KEY_LOWER: key_lower_in = csr_wr_data;
            default:       key_upper_in = key_upper_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_upper_ff <= '0;
         key_lower_ff <= '0;
      end else begin
         key_upper_ff <= key_upper_in;
         key_lower_ff <= key_lower_in;
      end
   end

   // link[0] leaves the whitening cell; link[r+1] leaves round cell r.
   // rdy[i] is the ready seen by whatever feeds link stage i.
   c2be_stage_type       link [0:ROUND_COUNT];
   logic                 rdy  [0:ROUND_COUNT+1];
   logic [ROUND_COUNT:0] busy;

   c2be_whiten_cell u_whiten (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_bus.valid),
      .in_ready  (rdy[0]),
      .in_blk    ({req_bus.block_upper, req_bus.block_lower}),
      .in_key    ({key_upper_ff, key_lower_ff}),
      .out_link  (link[0]),
      .out_ready (rdy[1])
   );

   for (genvar r = 0; r < ROUND_COUNT; r++) begin : g_round
      c2be_round_cell #(
         .ROUND_IDX  (r),
         .LAST_ROUND (r == ROUND_COUNT - 1)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_link   (link[r]),
         .in_ready  (rdy[r+1]),
         .out_link  (link[r+1]),
         .out_ready (rdy[r+2])
      );
   end

   for (genvar s = 0; s <= ROUND_COUNT; s++) begin : g_busy
      assign busy[s] = link[s].valid;
   end

   assign req_bus.ready           = rdy[0];
   assign rdy[ROUND_COUNT+1]      = rsp_bus.ready;
   assign rsp_bus.valid           = link[ROUND_COUNT].valid;
   assign rsp_bus.cipher_upper    = link[ROUND_COUNT].data.blk[0:BLOCK_BYTES/2-1];
   assign rsp_bus.cipher_lower    = link[ROUND_COUNT].data.blk[BLOCK_BYTES/2:BLOCK_BYTES-1];

   // A receiver that is ready, or an empty output cell, leaves room all along the row.
   `C2BE_ASSERT_IMPL(a_ready_follows_rsp, clock, reset, rsp_bus.ready, req_bus.ready, "input stalled while the receiver takes beats")
   `C2BE_ASSERT_IMPL(a_ready_when_drained, clock, reset, !rsp_bus.valid, req_bus.ready, "input stalled with an empty output cell")
   // A beat entering an empty row reaches the output once it has passed every cell.
   `C2BE_ASSERT_IMPL(a_latency_empty, clock, reset, req_bus.valid && req_bus.ready && (busy == '0), ##(ROUND_COUNT+1) rsp_bus.valid, "block missing at the end of an empty pipeline")

endmodule

@@ bench/testbench.sv @@
// Self-checking testbench for the Curupira-2 block encryption pipeline.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import c2be_pkg::*;

   // The block is built with the standard ten rounds; the round count also sets the settling pause.
   localparam int ROUNDS          = 10;
   localparam int SETTLE_CYCLES   = ROUNDS + 4;
   localparam int HOLD_OFF_CYCLES = 90;
   localparam int RANDOM_PHASES   = 5;
   localparam int PHASE_BLOCKS    = 106;
   localparam int CYCLE_LIMIT     = 200_000;

   // Both 4-bit mini-boxes are packed with entry 0 in the top nibble.
   localparam logic [63:0] BOX_P = 64'h3FE0_54BC_DA96_7821;
   localparam logic [63:0] BOX_Q = 64'h9E56_A23C_F04D_7B18;

   typedef struct packed {
      logic [HALF_BITS-1:0] upper;
      logic [HALF_BITS-1:0] lower;
   } cipher_pair;

   // The scoreboard keeps its own copy of the key. It enciphers every block when its
   // beat is taken and keeps the ciphertexts in order until they leave the block.
   class cipher_scoreboard;
      cipher_pair           expected_ciphers[$];
      logic [HALF_BITS-1:0] key_upper_copy;
      logic [HALF_BITS-1:0] key_lower_copy;
      int                   errors;
      int                   checked;

      function new();
         key_upper_copy = '0;
         key_lower_copy = '0;
         errors         = 0;
         checked        = 0;
      endfunction

      function logic [3:0] box_p(logic [3:0] i);
         return BOX_P[(15 - i) * 4 +: 4];
      endfunction

      function logic [3:0] box_q(logic [3:0] i);
         return BOX_Q[(15 - i) * 4 +: 4];
      endfunction

      // The S-box is built from the mini-boxes in three passes. Each pass after the first
      // crosses two bits of each nibble into the other one.
      function logic [7:0] sub_byte(logic [7:0] v);
         logic [3:0] a_hi;
         logic [3:0] a_lo;
         logic [3:0] b_hi;
         logic [3:0] b_lo;
         logic [3:0] c_hi;
         logic [3:0] c_lo;
         a_hi = box_p(v[7:4]);
         a_lo = box_q(v[3:0]);
         b_hi = box_q({a_hi[3:2], 2'b00} ^ {2'b00, a_lo[3:2]});
         b_lo = box_p({a_hi[1:0], 2'b00} ^ {2'b00, a_lo[1:0]});
         c_hi = box_p({b_hi[3:2], 2'b00} ^ {2'b00, b_lo[3:2]});
         c_lo = box_q({b_hi[1:0], 2'b00} ^ {2'b00, b_lo[1:0]});
         return {c_hi, c_lo};
      endfunction

      function logic [7:0] gf_double(logic [7:0] v);
         return {v[6:0], 1'b0} ^ (v[7] ? XMUL_POLY : 8'h00);
      endfunction

      function logic [7:0] spread_up(logic [7:0] v);
         return (v << 5) ^ (v << 3);
      endfunction

      function logic [7:0] fold_down(logic [7:0] v);
         return v ^ (v >> 3) ^ (v >> 5);
      endfunction

      function c2be_bytes_type add_round_key(c2be_bytes_type b, c2be_bytes_type k);
         c2be_bytes_type r;
         r = b;
         for (int i = 0; i < BLOCK_BYTES; i += 3) begin
            r[i]   = b[i] ^ sub_byte(k[i]);
            r[i+1] = b[i+1] ^ k[i+1];
            r[i+2] = b[i+2] ^ k[i+2];
         end
         return r;
      endfunction

      function cipher_pair encipher(logic [HALF_BITS-1:0] pu, logic [HALF_BITS-1:0] pl);
         c2be_bytes_type st;
         c2be_bytes_type rk;
         logic [7:0]     fb;
         logic [7:0]     t;
         logic [7:0]     u;
         cipher_pair     res;
         st = {pu, pl};
         rk = {key_upper_copy, key_lower_copy};
         st = add_round_key(st, rk);
         for (int r = 0; r < ROUNDS; r++) begin
            {st[1], st[4]}  = {st[4], st[1]};
            {st[2], st[8]}  = {st[8], st[2]};
            {st[7], st[10]} = {st[10], st[7]};
            {st[5], st[11]} = {st[11], st[5]};
            for (int i = 0; i < BLOCK_BYTES; i++)
               st[i] = sub_byte(st[i]);
            fb = rk[0] ^ sub_byte(8'(r));
            rk = {rk[1:11], fb};
            rk[9]  = rk[9] ^ fold_down(fb);
            rk[10] = rk[10] ^ spread_up(fb);
            if (r != ROUNDS - 1) begin
               for (int i = 0; i < BLOCK_BYTES; i += 3) begin
                  t = gf_double(st[i] ^ st[i+1] ^ st[i+2]);
                  u = gf_double(t);
                  st[i]   = st[i] ^ t;
                  st[i+1] = st[i+1] ^ u;
                  st[i+2] = st[i+2] ^ t ^ u;
               end
            end
            st = add_round_key(st, rk);
         end
         res.upper = st[0:5];
         res.lower = st[6:11];
         return res;
      endfunction

      function void load_key(logic index, logic [HALF_BITS-1:0] data);
         case (index)
            CSR_KEY_UPPER: key_upper_copy = data;
            CSR_KEY_LOWER: key_lower_copy = data;
         endcase
      endfunction

      function void note_block(logic [HALF_BITS-1:0] pu, logic [HALF_BITS-1:0] pl);
         expected_ciphers.push_back(encipher(pu, pl));
      endfunction

      function void check_cipher(logic [HALF_BITS-1:0] cu, logic [HALF_BITS-1:0] cl);
         cipher_pair exp;
         if (expected_ciphers.size() == 0) begin
            errors++;
            $error("ciphertext beat %h_%h arrived with no block in flight", cu, cl);
         end else begin
            exp = expected_ciphers.pop_front();
            checked++;
            if (cu !== exp.upper) begin
               errors++;
               $error("cipher_upper: expected %h, got %h", exp.upper, cu);
            end
            if (cl !== exp.lower) begin
               errors++;
               $error("cipher_lower: expected %h, got %h", exp.lower, cl);
            end
         end
      endfunction

      function int pending();
         return expected_ciphers.size();
      endfunction
   endclass

   logic                 clock;
   logic                 reset;
   logic                 csr_wr_en;
   logic                 csr_index;
   logic [HALF_BITS-1:0] csr_wr_data;

   c2be_req_if req_bus();
   c2be_rsp_if rsp_bus();

   cipher_scoreboard ledger;
   int               burst_left;
   int               blocks_sent;
   int               key_settings;
   int               cycle_count;
   bit               hold_off_due;

   curupira2_block_encrypt #(
      .ROUND_COUNT(ROUNDS)
   ) uut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   initial clock = 1'b0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Everything is sampled at the rising edge, before the nonblocking updates of that edge
   // land. Key writes are mirrored into the scoreboard at the same edge as they reach the
   // block. A block beat is noted before a ciphertext beat is checked, although as each
   // block passes through the registered cells the two can never belong to the same block.
   always @(posedge clock) begin
      if (!reset && ledger != null) begin
         if (csr_wr_en)
            ledger.load_key(csr_index, csr_wr_data);
         if (req_bus.valid && req_bus.ready)
            ledger.note_block(req_bus.block_upper, req_bus.block_lower);
         if (rsp_bus.valid && rsp_bus.ready)
            ledger.check_cipher(rsp_bus.cipher_upper, rsp_bus.cipher_lower);
      end
   end

   // The watchdog is set far above the slowest correct run. That run is about 550 blocks,
   // each behind a sender gap and a receiver stalling three beats in four, plus the long
   // hold-off and the pauses between phases.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d ciphertexts outstanding",
                  cycle_count, ledger.pending());
         $display("status: fail");
         $finish;
      end
   end

   // The receiver works through stretches of random length, each in one stall mode.
   // The modes are always ready, mostly ready, a fixed on-off pattern and mostly stalled.
   // The stimulus can request one long hold-off. During it the sender keeps offering
   // blocks, so the row of cells fills from the output end and req_bus.ready has to drop.
   initial begin
      int mode;
      int span;
      int period;
      int step;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      forever begin
         mode   = $urandom_range(0, 3);
         span   = $urandom_range(16, 80);
         period = $urandom_range(2, 5);
         step   = 0;
         while (step < span) begin
            if (hold_off_due) begin
               hold_off_due = 1'b0;
               rsp_bus.ready <= 1'b0;
               repeat (HOLD_OFF_CYCLES) @(posedge clock);
            end else begin
               case (mode)
                  0:       rsp_bus.ready <= 1'b1;
                  1:       rsp_bus.ready <= ($urandom_range(0, 3) != 0);
                  2:       rsp_bus.ready <= ((step % period) != 0);
                  default: rsp_bus.ready <= ($urandom_range(0, 3) == 0);
               endcase
               @(posedge clock);
            end
            step++;
         end
      end
   end

   // Offers one block and returns at the edge where its beat is taken. Blocks go out in
   // bursts with random gaps between them. Within a burst valid stays high from one beat
   // to the next, so it is never lowered and raised in the same time step.
   task automatic send_block(input logic [HALF_BITS-1:0] pu, input logic [HALF_BITS-1:0] pl);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_bus.valid       <= 1'b1;
      req_bus.block_upper <= pu;
      req_bus.block_lower <= pl;
      do @(posedge clock); while (!req_bus.ready);
      blocks_sent++;
   endtask

   // Lowers valid, then waits until every ciphertext has come back and the row is quiet.
   task automatic drain_pipeline();
      req_bus.valid <= 1'b0;
      while (ledger.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes both key halves on back-to-back edges. It is only called with the
   // pipeline drained, as the key must not change under a block in flight.
   task automatic set_key(input logic [HALF_BITS-1:0] ku, input logic [HALF_BITS-1:0] kl);
      csr_wr_en   <= 1'b1;
      csr_index   <= CSR_KEY_UPPER;
      csr_wr_data <= ku;
      @(posedge clock);
      csr_index   <= CSR_KEY_LOWER;
      csr_wr_data <= kl;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      key_settings++;
   endtask

   // Most halves are fully random. The rest are built byte by byte from all-zero bytes,
   // all-one bytes and random bytes, so that both extremes turn up inside random traffic.
   function automatic logic [HALF_BITS-1:0] random_half();
      logic [HALF_BITS-1:0] h;
      h = {16'($urandom), $urandom};
      if ($urandom_range(0, 7) >= 5) begin
         for (int i = 0; i < 6; i++) begin
            case ($urandom_range(0, 2))
               0: h[i*8 +: 8] = 8'h00;
               1: h[i*8 +: 8] = 8'hFF;
               default: h[i*8 +: 8] = 8'($urandom);
            endcase
         end
      end
      return h;
   endfunction

   initial begin
      ledger       = new();
      burst_left   = 0;
      blocks_sent  = 0;
      key_settings = 1;
      cycle_count  = 0;
      hold_off_due = 1'b0;

      reset               <= 1'b1;
      csr_wr_en           <= 1'b0;
      csr_index           <= CSR_KEY_UPPER;
      csr_wr_data         <= '0;
      req_bus.valid       <= 1'b0;
      req_bus.block_upper <= '0;
      req_bus.block_lower <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // The first blocks use the all-zero key left by reset. They cover the extreme
      // plaintexts and alternating bit patterns in both halves.
      send_block('0, '0);
      send_block('1, '1);
      send_block(48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555);
      send_block(48'h8000_0000_0000, 48'h0000_0000_0001);
      send_block(48'hFFFF_FFFF_FFFF, '0);
      send_block(48'h0123_4567_89AB, 48'hCDEF_FEDC_BA98);
      drain_pipeline();

      // The all-ones key drives every key byte, including those that the key addition
      // passes through the S-box, to its top value.
      set_key('1, '1);
      send_block('0, '0);
      send_block('1, '1);
      send_block(48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA);
      send_block('0, '1);
      drain_pipeline();

      set_key(48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555);
      send_block('0, '0);
      send_block('1, '1);
      send_block(48'hFF00_FF00_FF00, 48'h00FF_00FF_00FF);
      send_block(48'h0000_0000_0001, 48'h8000_0000_0000);
      drain_pipeline();

      // Keys with one half at each extreme.
      set_key('0, '1);
      send_block('0, '0);
      send_block('1, '1);
      send_block(48'h0F0F_0F0F_0F0F, 48'hF0F0_F0F0_F0F0);
      drain_pipeline();

      set_key('1, '0);
      send_block('0, '0);
      send_block('1, '1);
      send_block(48'h1357_9BDF_2468, 48'hACE0_8642_FDB9);
      drain_pipeline();

      // Random phases, each under a fresh key. The long receiver hold-off is requested
      // early in the first phase so that the input stalls while the sender is busy.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         set_key(random_half(), random_half());
         for (int n = 0; n < PHASE_BLOCKS; n++) begin
            if (phase == 0 && n == 8)
               hold_off_due = 1'b1;
            send_block(random_half(), random_half());
         end
         drain_pipeline();
      end

      $display("enciphered %0d blocks under %0d key settings, %0d ciphertexts checked,",
               blocks_sent, key_settings, ledger.checked);
      $display("with bursty input, patterned output stalls and one long output hold-off");
      if (ledger.errors == 0 && ledger.pending() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

@@ files.f @@
+incdir+rtl
rtl/c2be_pkg.sv
rtl/c2be_if.sv
rtl/c2be_whiten_cell.sv
rtl/c2be_round_cell.sv
rtl/curupira2_block_encrypt.sv
bench/testbench.sv
